FILE: rtl/pointer_event_queue_coalescer_macros.svh
// Assertion macros shared by the pointer event queue checker.
`ifndef POINTER_EVENT_QUEUE_COALESCER_MACROS_SVH
`define POINTER_EVENT_QUEUE_COALESCER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PECQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pecq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PECQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pecq assertion failed");

`endif

FILE: rtl/pecq_pkg.sv
// Package with codes, widths and shared types of the pointer event queue.
`timescale 1ns / 1ps
package pecq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TIMER_BITS_DEF  = 16;

  localparam int REQ_W   = 2;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 16;
  localparam int COORD_W = 15;
  localparam int MS_W    = 16;
  localparam int ENTRY_W = KIND_W + 2 * POS_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BADGE = 3'd3;

  localparam logic [MS_W-1:0] STUCK_RESET = 16'd600;
  localparam logic [MS_W-1:0] BADGE_RESET = 16'd3000;

  typedef struct packed {
    logic tick;
    logic clear;
  } timer_ctl_t;

endpackage

FILE: rtl/pecq_timers.sv
// Saturating millisecond counters for event silence and activity age.
`timescale 1ns / 1ps
module pecq_timers #(
  parameter int TIMER_BITS = pecq_pkg::TIMER_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pecq_pkg::timer_ctl_t   ctl_i,
  output logic [TIMER_BITS-1:0]  ms_event_o,
  output logic [TIMER_BITS-1:0]  ms_activity_o
);

  logic [TIMER_BITS-1:0] ms_event_q, ms_event_d;
  logic [TIMER_BITS-1:0] ms_activity_q, ms_activity_d;

  always_comb begin
    ms_event_d    = ms_event_q;
    ms_activity_d = ms_activity_q;
    if (ctl_i.clear) begin
      ms_event_d    = '0;
      ms_activity_d = '0;
    end else if (ctl_i.tick) begin
      if (ms_event_q != '1) begin
        ms_event_d = ms_event_q + TIMER_BITS'(1);
      end
      if (ms_activity_q != '1) begin
        ms_activity_d = ms_activity_q + TIMER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_event_q    <= '0;
      ms_activity_q <= '1;
    end else begin
      ms_event_q    <= ms_event_d;
      ms_activity_q <= ms_activity_d;
    end
  end

  assign ms_event_o    = ms_event_q;
  assign ms_activity_o = ms_activity_q;

endmodule

FILE: rtl/pointer_event_queue_coalescer.sv
// Top level of the remote pointer event queue with move coalescing.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one request per transaction:
// a push of a press, release or move, a read, or a one millisecond tick.
// A push or a tick is absorbed and gives no result. A read gives
// exactly one result transaction on the output channel (out_valid_o / out_stall_i).
// A read walks the ring one entry per cycle through its single read port. On a
// non-empty ring it pops the oldest entry and, when that is a move, folds into it
// every directly following move (at most QUEUE_DEPTH - 1 of them); a press or
// release that ends the run stays queued. The next request can be accepted in the
// same cycle that the result is offered.
// Stuck check, both clamps and the badge test share one comparator, one per cycle.
// in_stall_o is high while a read is in progress. The result is held in an
// output register; when the receiver stalls, it stays valid and unchanged, and
// pushes and ticks are still accepted. A further read finishes its walk and
// then waits until the held result is taken.
// Configuration writes are taken in every cycle (cfg_ready_o is tied high).
// Reset empties the ring, releases the pointer at (0, 0), zeroes the silence
// counter, saturates the activity counter and loads the register defaults.
module pointer_event_queue_coalescer #(
  parameter int QUEUE_DEPTH = pecq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIMER_BITS  = pecq_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pecq_pkg::REQ_W-1:0]        req_type_i,
  input  logic [pecq_pkg::KIND_W-1:0]       event_kind_i,
  input  logic signed [pecq_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [pecq_pkg::POS_W-1:0] pos_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pecq_pkg::COORD_W-1:0]      point_x_o,
  output logic [pecq_pkg::COORD_W-1:0]      point_y_o,
  output logic                              is_pressed_o,
  output logic                              more_pending_o,
  output logic                              badge_on_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pecq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pecq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W  = (TIMER_BITS > pecq_pkg::MS_W) ? TIMER_BITS : pecq_pkg::MS_W;
  localparam int KIND_HI = pecq_pkg::ENTRY_W - 1;
  localparam int KIND_LO = 2 * pecq_pkg::POS_W;
  localparam int X_HI    = KIND_LO - 1;
  localparam int X_LO    = pecq_pkg::POS_W;
  localparam int Y_HI    = pecq_pkg::POS_W - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STUCK,
    S_FIRST,
    S_PEEK,
    S_CLAMPX,
    S_CLAMPY,
    S_REPORT
  } state_e;

  // Configuration registers.
  logic [pecq_pkg::COORD_W-1:0] max_x_q, max_y_q;
  logic [pecq_pkg::MS_W-1:0]    stuck_q, badge_q;

  // Sequencer and ring control.
  state_e                         state_q, state_d;
  logic [PTR_W-1:0]               head_q, head_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic                           pressed_q, pressed_d;
  logic [pecq_pkg::COORD_W-1:0]   cur_x_q, cur_x_d;
  logic [pecq_pkg::COORD_W-1:0]   cur_y_q, cur_y_d;
  logic [pecq_pkg::ENTRY_W-1:0]   ent_q, ent_d;

  // Output register.
  logic                           out_valid_q, out_valid_d;
  logic [pecq_pkg::COORD_W-1:0]   out_x_q, out_x_d;
  logic [pecq_pkg::COORD_W-1:0]   out_y_q, out_y_d;
  logic                           out_pressed_q, out_pressed_d;
  logic                           out_more_q, out_more_d;
  logic                           out_badge_q, out_badge_d;

  // Ring memory.
  logic [pecq_pkg::ENTRY_W-1:0]   mem_q [QUEUE_DEPTH];
  logic [pecq_pkg::ENTRY_W-1:0]   rd_data_q;
  logic                           rd_en;
  logic [PTR_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [PTR_W-1:0]               wr_addr;
  logic [pecq_pkg::ENTRY_W-1:0]   wr_data;

  // Shared comparator.
  logic [CMP_W-1:0]               cmp_a, cmp_b;
  logic                           cmp_gt;

  logic                           in_accept;
  logic                           out_take;
  logic                           full;
  logic [PTR_W-1:0]               head_next;
  logic [PTR_W:0]                 tail_sum;
  logic [PTR_W-1:0]               tail;
  logic [pecq_pkg::KIND_W-1:0]    rd_kind;
  logic [pecq_pkg::KIND_W-1:0]    ent_kind;
  logic signed [pecq_pkg::POS_W-1:0] ent_x, ent_y;
  logic [pecq_pkg::COORD_W-1:0]   clamp_res;
  logic [pecq_pkg::COORD_W-1:0]   clamp_bound;
  logic signed [pecq_pkg::POS_W-1:0] clamp_in;
  pecq_pkg::timer_ctl_t           timer_ctl;
  logic [TIMER_BITS-1:0]          ms_event;
  logic [TIMER_BITS-1:0]          ms_activity;

  pecq_timers #(
    .TIMER_BITS (TIMER_BITS)
  ) u_timers (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (timer_ctl),
    .ms_event_o    (ms_event),
    .ms_activity_o (ms_activity)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_next = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

  // The count is at most the depth here, so one conditional subtract wraps the sum.
  assign tail_sum = (PTR_W + 1)'(head_q) + (PTR_W + 1)'(count_q);
  assign tail     = (tail_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
                  ? PTR_W'(tail_sum - (PTR_W + 1)'(QUEUE_DEPTH))
                  : PTR_W'(tail_sum);

  assign rd_kind  = rd_data_q[KIND_HI:KIND_LO];
  assign ent_kind = ent_q[KIND_HI:KIND_LO];
  assign ent_x    = ent_q[X_HI:X_LO];
  assign ent_y    = ent_q[Y_HI:0];

  // Operand selection for the shared comparator; the result is a > b.
  always_comb begin
    clamp_in    = (state_q == S_CLAMPY) ? ent_y : ent_x;
    clamp_bound = (state_q == S_CLAMPY) ? max_y_q : max_x_q;
    unique case (state_q)
      S_STUCK: begin
        cmp_a = CMP_W'(ms_event);
        cmp_b = CMP_W'(stuck_q);
      end
      S_CLAMPX, S_CLAMPY: begin
        cmp_a = CMP_W'(clamp_in[pecq_pkg::COORD_W-1:0]);
        cmp_b = CMP_W'(clamp_bound);
      end
      S_REPORT: begin
        cmp_a = CMP_W'(badge_q);
        cmp_b = CMP_W'(ms_activity);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);

  always_comb begin
    if (clamp_in[pecq_pkg::POS_W-1]) begin
      clamp_res = '0;
    end else if (cmp_gt && (clamp_bound != '0)) begin
      clamp_res = clamp_bound;
    end else begin
      clamp_res = clamp_in[pecq_pkg::COORD_W-1:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    pressed_d     = pressed_q;
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    ent_d         = ent_q;
    out_valid_d   = out_take ? 1'b0 : out_valid_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_pressed_d = out_pressed_q;
    out_more_d    = out_more_q;
    out_badge_d   = out_badge_q;
    rd_en         = 1'b0;
    rd_addr       = head_q;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_data       = {event_kind_i, pos_x_i, pos_y_i};
    timer_ctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          priority if (req_type_i == pecq_pkg::REQ_PUSH) begin
            if (event_kind_i <= pecq_pkg::KIND_MOVE) begin
              wr_en = 1'b1;
              // A full ring drops its oldest entry, whose slot is then the tail.
              if (full) begin
                wr_addr = head_q;
                head_d  = head_next;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
          end else if (req_type_i == pecq_pkg::REQ_READ) begin
            state_d = S_STUCK;
          end else if (req_type_i == pecq_pkg::REQ_TICK) begin
            timer_ctl.tick = 1'b1;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_STUCK: begin
        if (pressed_q && cmp_gt) begin
          pressed_d = 1'b0;
        end
        if (count_q != '0) begin
          rd_en   = 1'b1;
          head_d  = head_next;
          count_d = count_q - CNT_W'(1);
          state_d = S_FIRST;
        end else begin
          state_d = S_REPORT;
        end
      end
      S_FIRST: begin
        ent_d = rd_data_q;
        if ((rd_kind == pecq_pkg::KIND_MOVE) && (count_q != '0)) begin
          rd_en   = 1'b1;
          state_d = S_PEEK;
        end else begin
          state_d = S_CLAMPX;
        end
      end
      S_PEEK: begin
        // The head entry is popped only when it is another move.
        if (rd_kind == pecq_pkg::KIND_MOVE) begin
          ent_d   = rd_data_q;
          head_d  = head_next;
          count_d = count_q - CNT_W'(1);
          if (count_q > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = head_next;
          end else begin
            state_d = S_CLAMPX;
          end
        end else begin
          state_d = S_CLAMPX;
        end
      end
      S_CLAMPX: begin
        cur_x_d         = clamp_res;
        timer_ctl.clear = 1'b1;
        if (ent_kind == pecq_pkg::KIND_PRESS) begin
          pressed_d = 1'b1;
        end else if (ent_kind == pecq_pkg::KIND_RELEASE) begin
          pressed_d = 1'b0;
        end
        state_d = S_CLAMPY;
      end
      S_CLAMPY: begin
        cur_y_d = clamp_res;
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_x_d       = cur_x_q;
          out_y_d       = cur_y_q;
          out_pressed_d = pressed_q;
          out_more_d    = (count_q != '0);
          out_badge_d   = cmp_gt;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= '0;
      count_q       <= '0;
      pressed_q     <= 1'b0;
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      out_valid_q   <= 1'b0;
      max_x_q       <= '0;
      max_y_q       <= '0;
      stuck_q       <= pecq_pkg::STUCK_RESET;
      badge_q       <= pecq_pkg::BADGE_RESET;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      count_q       <= count_d;
      pressed_q     <= pressed_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      out_valid_q   <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pecq_pkg::CFG_MAX_X: max_x_q <= cfg_data_i[pecq_pkg::COORD_W-1:0];
          pecq_pkg::CFG_MAX_Y: max_y_q <= cfg_data_i[pecq_pkg::COORD_W-1:0];
          pecq_pkg::CFG_STUCK: stuck_q <= cfg_data_i;
          pecq_pkg::CFG_BADGE: badge_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    ent_q         <= ent_d;
    out_x_q       <= out_x_d;
    out_y_q       <= out_y_d;
    out_pressed_q <= out_pressed_d;
    out_more_q    <= out_more_d;
    out_badge_q   <= out_badge_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign is_pressed_o   = out_pressed_q;
  assign more_pending_o = out_more_q;
  assign badge_on_o     = out_badge_q;

endmodule

FILE: rtl/pecq_checker.sv
// Port-level checker for the pointer event queue, bound to the top level.
`timescale 1ns / 1ps
`include "pointer_event_queue_coalescer_macros.svh"
module pecq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [pecq_pkg::REQ_W-1:0]        req_type_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [pecq_pkg::COORD_W-1:0]      point_x_o,
  input logic [pecq_pkg::COORD_W-1:0]      point_y_o,
  input logic                              is_pressed_o,
  input logic                              more_pending_o,
  input logic                              badge_on_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  logic in_accept;
  logic out_hold;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_hold  = out_valid_o && out_stall_i;

  // A stalled result transaction stays offered.
  `PECQ_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_hold, out_valid_o)

  // A stalled result transaction keeps its payload.
  `PECQ_ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_hold,
    $stable(point_x_o) && $stable(point_y_o) && $stable(is_pressed_o)
    && $stable(more_pending_o) && $stable(badge_on_o))

  // A read occupies the sequencer, so the next request must wait.
  `PECQ_ASSERT_NEXT(a_read_blocks_input, clk_i, rst_ni,
    in_accept && (req_type_i == pecq_pkg::REQ_READ), in_stall_o)

  // Pushes and ticks never create a result transaction.
  `PECQ_ASSERT_NEXT(a_no_result_from_push_tick, clk_i, rst_ni,
    in_accept && (req_type_i != pecq_pkg::REQ_READ) && !out_valid_o, !out_valid_o)

  // Configuration writes are always taken.
  `PECQ_ASSERT_IMPLY(a_cfg_always_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind pointer_event_queue_coalescer pecq_checker u_pecq_checker (.*);
